// ===== hw/rtl/tscs_pkg.sv =====
// Package for the two-stack cursor sequence.
// Holds the operation codes and the control state type; no dependencies.
package tscs_pkg;

    localparam int FUNC_BITS = 2;
    localparam int CAR_FIELD_BITS = 16;
    localparam int IN_DATA_BITS = 16;
    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_MOVE_LEFT  = 2'd0,
        FN_MOVE_RIGHT = 2'd1,
        FN_DELETE     = 2'd2,
        FN_INSERT     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/tscs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Used for both stacks of the cursor sequence; no dependencies.
module tscs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/two_stack_cursor_sequence.sv =====
// Two-stack cursor sequence (gap buffer).
// Input stream: s_tuser carries the operation (move left, move right, delete,
// insert), s_tdata the element for an insert. Every input transaction gives
// exactly one output transaction on m_tdata: the active element, whether the
// sequence is nonempty, and a flag for an insert refused at full capacity.
// An insert or an ignored operation goes from acceptance through S_OUT to the
// output register; a move or delete that pops a stack goes through S_FETCH and
// then S_OUT, since the new active element comes from a stack RAM with a
// registered read. A new transaction is accepted only in S_IDLE, once the
// result of the last one has been loaded into the output register.
// The state is two RAMs (left and right stack) plus two counts and a copy of
// the active element in a register.
// Reset clears the counts (empty sequence); the RAM contents are left as is.
// The output register holds a result while m_tready is low; no new input
// transaction is accepted while a result waits in S_OUT for the slot to free.
module two_stack_cursor_sequence #(
    parameter int CAPACITY = 64,
    parameter int CAR_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tscs_pkg::IN_DATA_BITS-1:0] s_tdata,  // [15:0] car_value
    input  logic [tscs_pkg::FUNC_BITS-1:0]    s_tuser,  // [1:0] func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] active_car, [16] has_active, [17] refused, [23:18] zero
    output logic [tscs_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    import tscs_pkg::*;

    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int STORE_BITS = (CAR_BITS < CAR_FIELD_BITS) ? CAR_BITS : CAR_FIELD_BITS;
    localparam logic [CNT_BITS:0] CAP_SUM = (CNT_BITS + 1)'(CAPACITY);
    localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);
    localparam logic [CNT_BITS-1:0] ONE = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] TWO = CNT_BITS'(2);

    state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]     lc_reg, lc_next;
    logic [CNT_BITS-1:0]     rc_reg, rc_next;
    logic [STORE_BITS-1:0]   active_reg, active_next;
    logic                    refused_reg, refused_next;
    logic                    fetch_left_reg, fetch_left_next;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;

    logic                    accept;
    logic                    go_fetch;
    func_t                   func;
    logic [STORE_BITS-1:0]   car_val;
    logic [CNT_BITS-1:0]     lc_dec, rc_dec2;
    logic [CNT_BITS:0]       fill;

    logic                    l_we, r_we;
    logic [ADDR_BITS-1:0]    l_waddr, r_waddr, l_raddr, r_raddr;
    logic [STORE_BITS-1:0]   l_wdata, r_wdata, l_rdata, r_rdata;

    logic                    out_free;
    logic [CAR_FIELD_BITS-1:0] res_car;
    logic                    res_has;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign car_val  = s_tdata[STORE_BITS-1:0];
    assign lc_dec   = lc_reg - ONE;
    assign rc_dec2  = rc_reg - TWO;
    assign fill     = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    tscs_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (CAPACITY)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    tscs_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (CAPACITY)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    // decide whether the accepted operation pops a stack
    always_comb
    begin
        go_fetch = 1'b0;
        case (func)
            FN_MOVE_LEFT:  go_fetch = (rc_reg >= TWO) && (lc_reg < CAP_CNT);
            FN_MOVE_RIGHT: go_fetch = (lc_reg != '0) && (rc_reg < CAP_CNT);
            FN_DELETE:     go_fetch = (rc_reg >= TWO) || ((rc_reg == ONE) && (lc_reg != '0));
            FN_INSERT:     go_fetch = 1'b0;
            default:       go_fetch = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = go_fetch ? S_FETCH : S_OUT;
                end
            end
            S_FETCH: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // stack RAM accesses and count updates
    always_comb
    begin
        lc_next         = lc_reg;
        rc_next         = rc_reg;
        active_next     = active_reg;
        refused_next    = refused_reg;
        fetch_left_next = fetch_left_reg;
        l_we            = 1'b0;
        l_waddr         = lc_reg[ADDR_BITS-1:0];
        l_wdata         = active_reg;
        l_raddr         = lc_dec[ADDR_BITS-1:0];
        r_we            = 1'b0;
        r_waddr         = rc_reg[ADDR_BITS-1:0];
        r_wdata         = car_val;
        r_raddr         = rc_dec2[ADDR_BITS-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    refused_next = 1'b0;
                    case (func)
                        FN_MOVE_LEFT:
                        begin
                            if (go_fetch)
                            begin
                                // push active onto left, new active is next one down
                                l_we            = 1'b1;
                                lc_next         = lc_reg + ONE;
                                rc_next         = rc_reg - ONE;
                                fetch_left_next = 1'b0;
                            end
                        end
                        FN_MOVE_RIGHT:
                        begin
                            if (go_fetch)
                            begin
                                lc_next         = lc_dec;
                                fetch_left_next = 1'b1;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (rc_reg >= TWO)
                            begin
                                rc_next         = rc_reg - ONE;
                                fetch_left_next = 1'b0;
                            end
                            else if (rc_reg == ONE)
                            begin
                                // last on the right: refill from the left neighbor
                                rc_next         = '0;
                                fetch_left_next = 1'b1;
                                if (lc_reg != '0)
                                begin
                                    lc_next = lc_dec;
                                end
                            end
                        end
                        FN_INSERT:
                        begin
                            if ((fill >= CAP_SUM) || (rc_reg >= CAP_CNT))
                            begin
                                refused_next = 1'b1;
                            end
                            else
                            begin
                                r_we        = 1'b1;
                                rc_next     = rc_reg + ONE;
                                active_next = car_val;
                            end
                        end
                        default:
                        begin
                            refused_next = 1'b0;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (fetch_left_reg)
                begin
                    // move the left top onto the right stack
                    r_we        = 1'b1;
                    r_wdata     = l_rdata;
                    rc_next     = rc_reg + ONE;
                    active_next = l_rdata;
                end
                else
                begin
                    active_next = r_rdata;
                end
            end
            default:
            begin
                l_we = 1'b0;
            end
        endcase
    end

    assign res_has = (rc_reg != '0) || (lc_reg != '0);
    assign res_car = (rc_reg != '0) ? CAR_FIELD_BITS'(active_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lc_reg         <= '0;
            rc_reg         <= '0;
            refused_reg    <= 1'b0;
            fetch_left_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lc_reg         <= lc_next;
            rc_reg         <= rc_next;
            refused_reg    <= refused_next;
            fetch_left_reg <= fetch_left_next;
            if ((state_reg == S_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        if ((state_reg == S_OUT) && out_free)
        begin
            m_tdata_reg <= OUT_DATA_BITS'({refused_reg, res_has, res_car});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
